>>> hdl/ansi_escape_stripper_unit_assert.svh
// Assertion macros shared by the stripper unit modules.
`ifndef ANSI_ESCAPE_STRIPPER_UNIT_ASSERT_SVH
`define ANSI_ESCAPE_STRIPPER_UNIT_ASSERT_SVH
// Property that must hold at every edge outside reset.
`define ASU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define ASU_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

>>> hdl/asu_pkg.sv
// Package: byte codes, parse modes and the front-to-back command word.
package asu_pkg;

    localparam logic [7:0] BYTE_BEL       = 8'h07;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_LF        = 8'h0a;
    localparam logic [7:0] BYTE_CR        = 8'h0d;
    localparam logic [7:0] BYTE_ESC       = 8'h1b;
    localparam logic [7:0] PRINT_LOW      = 8'h20;
    localparam logic [7:0] FINAL_LOW      = 8'h40;
    localparam logic [7:0] BYTE_LBRACKET  = 8'h5b;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5c;
    localparam logic [7:0] BYTE_RBRACKET  = 8'h5d;
    localparam logic [7:0] FINAL_HIGH     = 8'h7e;

    // Command queue depth (power of two, pointers wrap naturally).
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_CSI    = 2'd2,
        MODE_OSC    = 2'd3
    } t_mode;

    // One command per input word that produces any result or ends the buffer.
    typedef struct packed {
        logic       lf;    // flushed CR: LF goes out first
        logic       txt;   // data carries a text byte
        logic [7:0] data;
        logic       last;  // final word of the buffer
    } t_cmd;

endpackage

>>> hdl/asu_front.sv
// Front end: parses input words and issues commands to the queue.
module asu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_last_of_buffer,
    output logic          o_cmd_push,
    output asu_pkg::t_cmd o_cmd
);

    asu_pkg::t_mode r_mode, n_mode;
    logic           r_osc_esc, n_osc_esc;
    logic           r_crp, n_crp;
    logic           is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= asu_pkg::MODE_NORMAL;
            r_osc_esc <= 1'b0;
            r_crp     <= 1'b0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_osc_esc <= n_osc_esc;
            r_crp     <= n_crp;
        end
    end

    always_comb begin
        is_final  = (i_in_byte >= asu_pkg::FINAL_LOW) && (i_in_byte <= asu_pkg::FINAL_HIGH);
        n_mode    = r_mode;
        n_osc_esc = r_osc_esc;
        n_crp     = 1'b0;
        o_cmd.lf   = r_crp && (i_in_byte != asu_pkg::BYTE_LF);
        o_cmd.txt  = 1'b0;
        o_cmd.data = i_in_byte;
        o_cmd.last = i_last_of_buffer;
        unique case (r_mode)
            asu_pkg::MODE_OSC: begin
                if ((i_in_byte == asu_pkg::BYTE_BEL) ||
                    (r_osc_esc && (i_in_byte == asu_pkg::BYTE_BACKSLASH))) begin
                    n_mode = asu_pkg::MODE_NORMAL;
                end
                n_osc_esc = (i_in_byte == asu_pkg::BYTE_ESC);
            end
            asu_pkg::MODE_CSI: begin
                if (is_final) begin
                    n_mode = asu_pkg::MODE_NORMAL;
                end
            end
            asu_pkg::MODE_ESCAPE: begin
                if (i_in_byte == asu_pkg::BYTE_RBRACKET) begin
                    n_mode    = asu_pkg::MODE_OSC;
                    n_osc_esc = 1'b0;
                end else if (i_in_byte == asu_pkg::BYTE_LBRACKET) begin
                    n_mode = asu_pkg::MODE_CSI;
                end else if (is_final) begin
                    n_mode = asu_pkg::MODE_NORMAL;
                end
            end
            default: begin
                if (i_in_byte == asu_pkg::BYTE_ESC) begin
                    n_mode = asu_pkg::MODE_ESCAPE;
                end else if (i_in_byte == asu_pkg::BYTE_CR) begin
                    // final CR goes out as LF straight away
                    if (i_last_of_buffer) begin
                        o_cmd.txt  = 1'b1;
                        o_cmd.data = asu_pkg::BYTE_LF;
                    end else begin
                        n_crp = 1'b1;
                    end
                end else if ((i_in_byte >= asu_pkg::PRINT_LOW) ||
                             (i_in_byte == asu_pkg::BYTE_LF) ||
                             (i_in_byte == asu_pkg::BYTE_TAB)) begin
                    o_cmd.txt = 1'b1;
                end
            end
        endcase
        if (i_last_of_buffer) begin
            n_mode    = asu_pkg::MODE_NORMAL;
            n_osc_esc = 1'b0;
            n_crp     = 1'b0;
        end
        o_cmd_push = i_accept && (o_cmd.lf || o_cmd.txt || o_cmd.last);
    end

endmodule

>>> hdl/asu_cmd_queue.sv
// Short command queue between the front and back ends.
`include "ansi_escape_stripper_unit_assert.svh"
module asu_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  asu_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output asu_pkg::t_cmd o_rdata,
    output logic          o_nempty
);

    asu_pkg::t_cmd                mem [asu_pkg::Q_DEPTH];
    logic [asu_pkg::Q_AW-1:0]     r_wp, r_rp;
    logic [asu_pkg::Q_CW-1:0]     r_cnt;

    assign o_full   = (r_cnt == asu_pkg::Q_CW'(asu_pkg::Q_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_rdata  = mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `ASU_NEVER(a_q_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")
    `ASU_NEVER(a_q_underflow, i_clk, i_rst_n, i_pop && !o_nempty, "pop from empty queue")
    `ASU_ASSERT(a_q_fill, i_clk, i_rst_n, (i_push && !i_pop && (r_cnt == asu_pkg::Q_CW'(asu_pkg::Q_DEPTH - 1))) |=> o_full, "queue did not fill")

endmodule

>>> hdl/asu_back.sv
// Back end: expands commands into result words behind an output register.
`include "ansi_escape_stripper_unit_assert.svh"
module asu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_nempty,
    input  asu_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_valid,
    output logic          o_end_of_buffer
);

    logic       r_valid, n_valid;
    logic       r_phase, n_phase;   // LF of a two-word command already out
    logic [7:0] r_byte, n_byte;
    logic       r_bv, n_bv;
    logic       r_eob, n_eob;
    logic       load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_bv   <= n_bv;
        r_eob  <= n_eob;
    end

    always_comb begin
        load      = i_cmd_nempty && (!r_valid || i_pop);
        n_valid   = r_valid && !i_pop;
        n_phase   = r_phase;
        n_byte    = r_byte;
        n_bv      = r_bv;
        n_eob     = r_eob;
        o_cmd_pop = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (i_cmd.lf && i_cmd.txt && !r_phase) begin
                n_byte  = asu_pkg::BYTE_LF;
                n_bv    = 1'b1;
                n_eob   = 1'b0;
                n_phase = 1'b1;
            end else begin
                o_cmd_pop = 1'b1;
                n_phase   = 1'b0;
                n_eob     = i_cmd.last;
                if (r_phase || (!i_cmd.lf && i_cmd.txt)) begin
                    n_byte = i_cmd.data;
                    n_bv   = 1'b1;
                end else if (i_cmd.lf) begin
                    n_byte = asu_pkg::BYTE_LF;
                    n_bv   = 1'b1;
                end else begin
                    // bare end marker
                    n_byte = 8'h00;
                    n_bv   = 1'b0;
                end
            end
        end
    end

    assign o_empty         = !r_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bv;
    assign o_end_of_buffer = r_eob;

    `ASU_ASSERT(a_b_phase_cmd, i_clk, i_rst_n, r_phase |-> i_cmd_nempty, "second half lost its command")
    `ASU_ASSERT(a_b_phase_out, i_clk, i_rst_n, r_phase |-> r_valid, "second half without first word")
    `ASU_ASSERT(a_b_first_lf, i_clk, i_rst_n, $rose(r_phase) |-> ((r_byte == asu_pkg::BYTE_LF) && r_bv && !r_eob), "first half not a plain LF")

endmodule

>>> hdl/ansi_escape_stripper_unit.sv
// Throughput: one word in per cycle unless full, one result out per popped cycle.
// An input word may cause up to two results (flushed CR as LF, then the byte).
// A result passes the command queue and then the back end's output register.
// The input stalls only when the four-entry command queue is full.
// Reset (synchronous, active low): parse state, queue and output valid flag clear.
// Top level: ANSI escape stripper built as front parser, command queue and back end.
module ansi_escape_stripper_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input side, queue style
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_of_buffer,
    // result side, queue style
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_buffer
);

    // Front end parses every accepted word in the cycle it arrives; words that
    // give no result and do not end the buffer issue no command at all.
    logic          accept;
    logic          cmd_push;
    asu_pkg::t_cmd cmd_in;
    // Queue output towards the back end.
    asu_pkg::t_cmd cmd_out;
    logic          cmd_nempty;
    logic          cmd_pop;
    logic          q_full;

    assign accept = push && !q_full;
    assign full   = q_full;

    asu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_in_byte        (i_in_byte),
        .i_last_of_buffer (i_last_of_buffer),
        .o_cmd_push       (cmd_push),
        .o_cmd            (cmd_in)
    );

    // Queue decouples the parser from a stalled consumer.
    asu_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cmd_push),
        .i_wdata  (cmd_in),
        .o_full   (q_full),
        .i_pop    (cmd_pop),
        .o_rdata  (cmd_out),
        .o_nempty (cmd_nempty)
    );

    // Back end turns a command into one or two words in its output register.
    asu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_nempty    (cmd_nempty),
        .i_cmd           (cmd_out),
        .o_cmd_pop       (cmd_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_buffer (o_end_of_buffer)
    );

endmodule
